// ----- rtl/mgcs_pkg.sv -----
// Shared types, codes and sizes for the multigroup collision sampler.
// Depends on nothing; the top level and the testbench import it.
`timescale 1ns / 1ps
package mgcs_pkg;

    // Table sizing.
    localparam int MAX_GROUPS = 64;
    localparam int MAX_YIELD  = 16;
    localparam int GRP_AW     = $clog2(MAX_GROUPS);
    localparam int MAT_AW     = 2 * GRP_AW;
    localparam int MAT_DEPTH  = MAX_GROUPS * MAX_GROUPS;

    // Field and datapath widths.
    localparam int GRP_W  = 7;
    localparam int VAL_W  = 32;
    localparam int SUM_W  = VAL_W + GRP_AW;
    localparam int TOT_W  = SUM_W + 1;
    localparam int SEED_W = 64;
    localparam int CNT_W  = 5;
    localparam int YLD_W  = 9;

    // Operation codes.
    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_COLLIDE = 1'b1;

    // Table selects.
    localparam logic [2:0] SEL_CAPTURE  = 3'd0;
    localparam logic [2:0] SEL_FISSION  = 3'd1;
    localparam logic [2:0] SEL_NUBAR    = 3'd2;
    localparam logic [2:0] SEL_SCATTER  = 3'd3;
    localparam logic [2:0] SEL_SPECTRUM = 3'd4;

    // Record kinds and reactions.
    localparam logic       KIND_OUTCOME   = 1'b0;
    localparam logic       KIND_SECONDARY = 1'b1;
    localparam logic [1:0] RXN_CAPTURE    = 2'd0;
    localparam logic [1:0] RXN_SCATTER    = 2'd1;
    localparam logic [1:0] RXN_FISSION    = 2'd2;
    localparam logic [1:0] RXN_NONE       = 2'd3;

    // Status codes.
    localparam logic [2:0] STS_OK         = 3'd0;
    localparam logic [2:0] STS_ZERO_TOTAL = 3'd1;
    localparam logic [2:0] STS_EMPTY_SCAT = 3'd2;
    localparam logic [2:0] STS_EMPTY_SPEC = 3'd3;
    localparam logic [2:0] STS_BAD_GROUP  = 3'd4;

    // Configuration register indexes and reset values.
    localparam logic              CFG_GROUP_COUNT = 1'b0;
    localparam logic              CFG_SEED        = 1'b1;
    localparam logic [GRP_W-1:0]  GC_RESET        = 7'd64;
    localparam logic [SEED_W-1:0] SEED_RESET      = 64'd1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_WR_RD, S_WR_UPD, S_COL_RD, S_COL_DAT, S_MUL_LO,
        S_MUL_HI, S_DECIDE, S_WALK_RD, S_WALK_CHK, S_SEC_DRAW, S_EMIT
    } state_t;

    typedef struct packed {
        logic             kind;
        logic [1:0]       reaction;
        logic [GRP_W-1:0] grp;
        logic [CNT_W-1:0] count;
        logic [2:0]       status;
        logic             last;
    } rec_t;

    // One step of the xorshift64 generator.
    function automatic logic [SEED_W-1:0] xorshift(input logic [SEED_W-1:0] x);
        logic [SEED_W-1:0] a;
        logic [SEED_W-1:0] b;
        a = x ^ (x << 13);
        b = a ^ (a >> 7);
        return b ^ (b << 17);
    endfunction

endpackage

// ----- rtl/mgcs_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
module mgcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/multigroup_collision_sampler_unit.sv -----
// Top level of the multigroup collision sampler: sequencer, shared multiplier,
// table RAMs and output register. Depends on mgcs_pkg and mgcs_ram.
//
//   channel  | ports                 | direction | carries
//   s_       | s_valid / s_ready     | in        | write or collide beat
//   m_       | m_valid / m_ready     | out       | one result record per beat
//   cfg_     | cfg_valid / cfg_ready | in        | register index and data
//
// After reset a clearing pass zeroes all tables; s_ready is low then. A table write
// passes S_WR_RD and, for scatter and spectrum, S_WR_UPD. A collide reads its tables,
// forms a threshold in S_MUL_LO and S_MUL_HI, then decides; a scatter walk repeats the
// multiply and walks the row, one row RAM read per step, and each fission secondary
// draws, multiplies and walks its spectrum row alike. A low m_ready stalls each record.
// The block holds one item at a time; the output register lets the next beat be taken
// while the last record still waits on m_ready.
`timescale 1ns / 1ps
module multigroup_collision_sampler_unit
    import mgcs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_operation,
    input  logic [2:0]        s_table_select,
    input  logic [GRP_W-1:0]  s_incident_group,
    input  logic [GRP_W-1:0]  s_outgoing_group,
    input  logic [VAL_W-1:0]  s_table_value,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_record_kind,
    output logic [1:0]        m_reaction,
    output logic [GRP_W-1:0]  m_new_group,
    output logic [CNT_W-1:0]  m_secondary_count,
    output logic [2:0]        m_status,
    output logic              m_last,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [SEED_W-1:0] cfg_data
);

    state_t state_reg, state_next;

    logic [MAT_AW-1:0] clr_cnt_reg;
    logic [GRP_W-1:0]  gc_reg;
    logic [SEED_W-1:0] gen_reg;

    logic [2:0]        sel_reg;
    logic [GRP_W-1:0]  inc_reg;
    logic [GRP_W-1:0]  outg_reg;
    logic [VAL_W-1:0]  val_reg;

    logic [VAL_W-1:0]  cap_reg, fis_reg, nub_reg;
    logic [SUM_W-1:0]  sca_reg, fsum_reg;
    logic [TOT_W-1:0]  total_reg;

    logic [VAL_W-1:0]  u_reg;
    logic [TOT_W-1:0]  w_reg;
    logic [2*VAL_W-1:0] prod_reg;
    logic [TOT_W-1:0]  thr_reg;
    logic              walk_reg;
    logic              row_sel_reg;
    logic [GRP_W-1:0]  g_reg;
    logic [SUM_W-1:0]  acc_reg;
    logic [CNT_W-1:0]  yield_reg;
    logic [CNT_W-1:0]  sec_reg;
    rec_t              rec_reg;
    logic              m_valid_reg;
    rec_t              m_rec_reg;

    // RAM ports.
    logic              tab_we_cap, tab_we_fis, tab_we_nub, sum_we_s, sum_we_f;
    logic              mat_we_s, mat_we_f;
    logic [GRP_AW-1:0] tab_waddr, tab_raddr;
    logic [VAL_W-1:0]  tab_wdata;
    logic [SUM_W-1:0]  ssum_wdata, fsum_wdata;
    logic [MAT_AW-1:0] mat_waddr, mat_raddr;
    logic [VAL_W-1:0]  mat_wdata;
    logic [VAL_W-1:0]  cap_rd, fis_rd, nub_rd, smat_rd, fmat_rd;
    logic [SUM_W-1:0]  ssum_rd, fsum_rd;

    // Helper values.
    logic [GRP_W-1:0]   n_eff;
    logic [GRP_W-1:0]   inc_m1, outg_m1, g_m1;
    logic [GRP_AW-1:0]  inc_idx, outg_idx, g_idx;
    logic               inc_ok, outg_ok, in_bad;
    logic [SEED_W-1:0]  gen_step;
    logic [VAL_W-1:0]   uni;
    logic               out_free;
    logic [VAL_W-1:0]   row_rd;
    logic [SUM_W-1:0]   acc_sum;
    logic               hit;
    logic [VAL_W-1:0]   mul_b;
    logic [2*VAL_W-1:0] mul_out;
    logic [TOT_W-1:0]   total_rd;
    logic [TOT_W-1:0]   cap_sca;
    logic [YLD_W+VAL_W-1:0] yield_raw;
    logic [CNT_W-1:0]   yield_sat;
    logic [GRP_W-1:0]   g_found;

    // Effective group count saturated to 1..MAX_GROUPS.
    always_comb begin
        if (gc_reg == '0) begin
            n_eff = GRP_W'(1);
        end else if (gc_reg > GRP_W'(MAX_GROUPS)) begin
            n_eff = GRP_W'(MAX_GROUPS);
        end else begin
            n_eff = gc_reg;
        end
    end

    assign inc_m1   = inc_reg - 1'b1;
    assign outg_m1  = outg_reg - 1'b1;
    assign g_m1     = g_reg - 1'b1;
    assign inc_idx  = inc_m1[GRP_AW-1:0];
    assign outg_idx = outg_m1[GRP_AW-1:0];
    assign g_idx    = g_m1[GRP_AW-1:0];
    assign inc_ok   = (inc_reg != '0) && (inc_reg <= GRP_W'(MAX_GROUPS));
    assign outg_ok  = (outg_reg != '0) && (outg_reg <= GRP_W'(MAX_GROUPS));
    assign in_bad   = (s_incident_group == '0) || (s_incident_group > n_eff);

    // Uniform generator: the top half of the next xorshift state.
    assign gen_step = xorshift(gen_reg);
    assign uni      = gen_step[SEED_W-1:VAL_W];

    assign out_free = !m_valid_reg || m_ready;

    // Row walk accumulate and compare.
    assign row_rd  = row_sel_reg ? fmat_rd : smat_rd;
    assign acc_sum = acc_reg + SUM_W'(row_rd);
    assign hit     = {1'b0, acc_sum} > thr_reg;
    assign g_found = hit ? g_reg : '0;

    // Shared multiplier: low weight word first, then the high bits.
    assign mul_b   = (state_reg == S_MUL_LO) ? w_reg[VAL_W-1:0]
                                             : VAL_W'(w_reg[TOT_W-1:VAL_W]);
    assign mul_out = u_reg * mul_b;

    assign total_rd = TOT_W'(cap_rd) + TOT_W'(ssum_rd) + TOT_W'(fis_rd);
    assign cap_sca  = TOT_W'(cap_reg) + TOT_W'(sca_reg);

    // Fission yield floor(nubar + u), saturated.
    assign yield_raw = {1'b0, nub_reg, 8'b0} + (YLD_W+VAL_W)'(uni);
    assign yield_sat = (yield_raw[YLD_W+VAL_W-1:VAL_W] > YLD_W'(MAX_YIELD))
                       ? CNT_W'(MAX_YIELD) : yield_raw[VAL_W+CNT_W-1:VAL_W];

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                if (clr_cnt_reg == '1) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) begin
                    if (s_operation == OP_WRITE) begin
                        state_next = S_WR_RD;
                    end else if (in_bad) begin
                        state_next = S_EMIT;
                    end else begin
                        state_next = S_COL_RD;
                    end
                end
            end
            S_WR_RD: begin
                if (inc_ok && outg_ok
                    && (sel_reg == SEL_SCATTER || sel_reg == SEL_SPECTRUM)) begin
                    state_next = S_WR_UPD;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_WR_UPD:  state_next = S_IDLE;
            S_COL_RD:  state_next = S_COL_DAT;
            S_COL_DAT: state_next = S_MUL_LO;
            S_MUL_LO:  state_next = S_MUL_HI;
            S_MUL_HI:  state_next = walk_reg ? S_WALK_RD : S_DECIDE;
            S_DECIDE: begin
                if (total_reg != '0 && TOT_W'(cap_reg) <= thr_reg && cap_sca > thr_reg) begin
                    state_next = S_MUL_LO;
                end else begin
                    state_next = S_EMIT;
                end
            end
            S_WALK_RD: state_next = S_WALK_CHK;
            S_WALK_CHK: begin
                if (hit || g_reg == n_eff) begin
                    state_next = S_EMIT;
                end else begin
                    state_next = S_WALK_RD;
                end
            end
            S_SEC_DRAW: state_next = S_MUL_LO;
            S_EMIT: begin
                if (out_free) state_next = rec_reg.last ? S_IDLE : S_SEC_DRAW;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // RAM controls and handshake outputs.
    always_comb begin
        tab_we_cap = 1'b0;
        tab_we_fis = 1'b0;
        tab_we_nub = 1'b0;
        sum_we_s   = 1'b0;
        sum_we_f   = 1'b0;
        mat_we_s   = 1'b0;
        mat_we_f   = 1'b0;
        tab_waddr  = inc_idx;
        tab_raddr  = inc_idx;
        tab_wdata  = val_reg;
        mat_waddr  = {inc_idx, outg_idx};
        mat_raddr  = (state_reg == S_WALK_RD) ? {inc_idx, g_idx} : {inc_idx, outg_idx};
        mat_wdata  = val_reg;
        ssum_wdata = ssum_rd - SUM_W'(smat_rd) + SUM_W'(val_reg);
        fsum_wdata = fsum_rd - SUM_W'(fmat_rd) + SUM_W'(val_reg);
        case (state_reg)
            S_CLEAR: begin
                tab_we_cap = 1'b1;
                tab_we_fis = 1'b1;
                tab_we_nub = 1'b1;
                sum_we_s   = 1'b1;
                sum_we_f   = 1'b1;
                mat_we_s   = 1'b1;
                mat_we_f   = 1'b1;
                tab_waddr  = clr_cnt_reg[GRP_AW-1:0];
                tab_wdata  = '0;
                mat_waddr  = clr_cnt_reg;
                mat_wdata  = '0;
                ssum_wdata = '0;
                fsum_wdata = '0;
            end
            S_WR_RD: begin
                tab_we_cap = inc_ok && (sel_reg == SEL_CAPTURE);
                tab_we_fis = inc_ok && (sel_reg == SEL_FISSION);
                tab_we_nub = inc_ok && (sel_reg == SEL_NUBAR);
            end
            S_WR_UPD: begin
                mat_we_s = (sel_reg == SEL_SCATTER);
                sum_we_s = (sel_reg == SEL_SCATTER);
                mat_we_f = (sel_reg == SEL_SPECTRUM);
                sum_we_f = (sel_reg == SEL_SPECTRUM);
            end
            default: begin
            end
        endcase
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    // Control registers: state, clear counter, configuration and generator.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            gc_reg      <= GC_RESET;
            gen_reg     <= SEED_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) clr_cnt_reg <= clr_cnt_reg + 1'b1;

            // Draw a uniform wherever the sequencer consumes one.
            if (state_reg == S_COL_DAT || state_reg == S_SEC_DRAW
                || (state_reg == S_DECIDE && total_reg != '0
                    && TOT_W'(cap_reg) <= thr_reg)) begin
                gen_reg <= gen_step;
            end

            if (state_reg == S_EMIT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            // Configuration writes must arrive only while the block is idle; the block does not enforce this.
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_GROUP_COUNT: gc_reg <= cfg_data[GRP_W-1:0];
                    CFG_SEED:        gen_reg <= (cfg_data == '0) ? SEED_RESET : cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                sel_reg  <= s_table_select;
                inc_reg  <= s_incident_group;
                outg_reg <= s_outgoing_group;
                val_reg  <= s_table_value;
                rec_reg  <= '{kind: KIND_OUTCOME, reaction: RXN_NONE, grp: '0, count: '0,
                              status: STS_BAD_GROUP, last: 1'b1};
            end
            S_COL_DAT: begin
                cap_reg   <= cap_rd;
                fis_reg   <= fis_rd;
                nub_reg   <= nub_rd;
                sca_reg   <= ssum_rd;
                fsum_reg  <= fsum_rd;
                total_reg <= total_rd;
                u_reg     <= uni;
                w_reg     <= total_rd;
                walk_reg  <= 1'b0;
            end
            S_MUL_LO: begin
                prod_reg <= mul_out;
            end
            S_MUL_HI: begin
                thr_reg <= TOT_W'(prod_reg[2*VAL_W-1:VAL_W]) + mul_out[TOT_W-1:0];
                g_reg   <= GRP_W'(1);
                acc_reg <= '0;
            end
            S_DECIDE: begin
                if (total_reg == '0) begin
                    rec_reg <= '{kind: KIND_OUTCOME, reaction: RXN_NONE, grp: '0,
                                 count: '0, status: STS_ZERO_TOTAL, last: 1'b1};
                end else if (TOT_W'(cap_reg) > thr_reg) begin
                    rec_reg <= '{kind: KIND_OUTCOME, reaction: RXN_CAPTURE, grp: '0,
                                 count: '0, status: STS_OK, last: 1'b1};
                end else if (cap_sca > thr_reg) begin
                    u_reg       <= uni;
                    w_reg       <= TOT_W'(sca_reg);
                    walk_reg    <= 1'b1;
                    row_sel_reg <= 1'b0;
                end else begin
                    yield_reg   <= yield_sat;
                    sec_reg     <= '0;
                    row_sel_reg <= 1'b1;
                    rec_reg     <= '{kind: KIND_OUTCOME, reaction: RXN_FISSION, grp: '0,
                                     count: yield_sat, status: STS_OK,
                                     last: (yield_sat == '0)};
                end
            end
            S_WALK_CHK: begin
                acc_reg <= acc_sum;
                g_reg   <= g_reg + 1'b1;
                if (row_sel_reg) begin
                    rec_reg <= '{kind: KIND_SECONDARY, reaction: RXN_FISSION, grp: g_found,
                                 count: yield_reg,
                                 status: hit ? STS_OK : STS_EMPTY_SPEC,
                                 last: ((sec_reg + 1'b1) == yield_reg)};
                end else begin
                    rec_reg <= '{kind: KIND_OUTCOME, reaction: RXN_SCATTER, grp: g_found,
                                 count: '0, status: hit ? STS_OK : STS_EMPTY_SCAT,
                                 last: 1'b1};
                end
            end
            S_SEC_DRAW: begin
                u_reg    <= uni;
                w_reg    <= TOT_W'(fsum_reg);
                walk_reg <= 1'b1;
            end
            S_EMIT: begin
                if (out_free) begin
                    m_rec_reg <= rec_reg;
                    if (rec_reg.kind == KIND_SECONDARY) sec_reg <= sec_reg + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid           = m_valid_reg;
    assign m_record_kind     = m_rec_reg.kind;
    assign m_reaction        = m_rec_reg.reaction;
    assign m_new_group       = m_rec_reg.grp;
    assign m_secondary_count = m_rec_reg.count;
    assign m_status          = m_rec_reg.status;
    assign m_last            = m_rec_reg.last;

    // Per-group tables.
    mgcs_ram #(.WIDTH(VAL_W), .DEPTH(MAX_GROUPS)) u_cap (
        .aclk(aclk), .we(tab_we_cap), .waddr(tab_waddr), .wdata(tab_wdata),
        .raddr(tab_raddr), .rdata(cap_rd));
    mgcs_ram #(.WIDTH(VAL_W), .DEPTH(MAX_GROUPS)) u_fis (
        .aclk(aclk), .we(tab_we_fis), .waddr(tab_waddr), .wdata(tab_wdata),
        .raddr(tab_raddr), .rdata(fis_rd));
    mgcs_ram #(.WIDTH(VAL_W), .DEPTH(MAX_GROUPS)) u_nub (
        .aclk(aclk), .we(tab_we_nub), .waddr(tab_waddr), .wdata(tab_wdata),
        .raddr(tab_raddr), .rdata(nub_rd));
    mgcs_ram #(.WIDTH(SUM_W), .DEPTH(MAX_GROUPS)) u_ssum (
        .aclk(aclk), .we(sum_we_s), .waddr(tab_waddr), .wdata(ssum_wdata),
        .raddr(tab_raddr), .rdata(ssum_rd));
    mgcs_ram #(.WIDTH(SUM_W), .DEPTH(MAX_GROUPS)) u_fsum (
        .aclk(aclk), .we(sum_we_f), .waddr(tab_waddr), .wdata(fsum_wdata),
        .raddr(tab_raddr), .rdata(fsum_rd));

    // Scatter and spectrum matrices.
    mgcs_ram #(.WIDTH(VAL_W), .DEPTH(MAT_DEPTH)) u_smat (
        .aclk(aclk), .we(mat_we_s), .waddr(mat_waddr), .wdata(mat_wdata),
        .raddr(mat_raddr), .rdata(smat_rd));
    mgcs_ram #(.WIDTH(VAL_W), .DEPTH(MAT_DEPTH)) u_fmat (
        .aclk(aclk), .we(mat_we_f), .waddr(mat_waddr), .wdata(mat_wdata),
        .raddr(mat_raddr), .rdata(fmat_rd));

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the multigroup collision sampler.
// It needs mgcs_pkg and multigroup_collision_sampler_unit and predicts every record itself.
`timescale 1ns / 1ps
module tb_top
    import mgcs_pkg::*;
();

    localparam int LIMIT_CYCLES = 2000000;
    localparam int SETTLE       = 40;

    typedef struct packed {
        logic             op;
        logic [2:0]       sel;
        logic [GRP_W-1:0] inc;
        logic [GRP_W-1:0] outg;
        logic [VAL_W-1:0] val;
    } beat_t;

    typedef struct packed {
        beat_t b;
        logic  typed;
        rec_t  rec;
    } dir_row_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic              s_operation = OP_WRITE;
    logic [2:0]        s_table_select = SEL_CAPTURE;
    logic [GRP_W-1:0]  s_incident_group = '0;
    logic [GRP_W-1:0]  s_outgoing_group = '0;
    logic [VAL_W-1:0]  s_table_value = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_record_kind;
    logic [1:0]        m_reaction;
    logic [GRP_W-1:0]  m_new_group;
    logic [CNT_W-1:0]  m_secondary_count;
    logic [2:0]        m_status;
    logic              m_last;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic              cfg_index = CFG_GROUP_COUNT;
    logic [SEED_W-1:0] cfg_data = '0;

    multigroup_collision_sampler_unit i_dut (.*);

    // Clock with a 12 ns period.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Predictor copy of the tables, the registers and the generator.
    bit [31:0] xs_capture [MAX_GROUPS];
    bit [31:0] xs_fission [MAX_GROUPS];
    bit [31:0] nubar_q824 [MAX_GROUPS];
    bit [31:0] scat_mat [MAT_DEPTH];
    bit [31:0] spec_mat [MAT_DEPTH];
    bit [37:0] scat_sum [MAX_GROUPS];
    bit [37:0] spec_sum [MAX_GROUPS];
    bit [6:0]  groups_reg = 7'd64;
    bit [63:0] rng_state = 64'd1;

    rec_t     expected_records[$];
    dir_row_t dir[$];
    int       fail_count = 0;
    int       cycle_count = 0;
    bit       calm = 1'b0;
    int       stall_left = 0;

    function automatic int groups_in_use();
        if (groups_reg < 1) return 1;
        if (groups_reg > MAX_GROUPS) return MAX_GROUPS;
        return int'(groups_reg);
    endfunction

    function automatic bit [63:0] next_uniform();
        bit [63:0] x;
        x = rng_state;
        x ^= x << 13;
        x ^= x >> 7;
        x ^= x << 17;
        rng_state = x;
        return x >> 32;
    endfunction

    // floor(u * w / 2^32), split so nothing overflows 64 bits.
    function automatic bit [63:0] scaled(bit [63:0] u, bit [63:0] w);
        bit [63:0] hi;
        bit [63:0] lo;
        hi = w >> 32;
        lo = w & 64'hFFFF_FFFF;
        return u * hi + ((u * lo) >> 32);
    endfunction

    // First group whose running sum passes the threshold, 0 if none does.
    function automatic int pick_group(bit spectrum, int inc, int n, bit [63:0] thr);
        bit [63:0] acc;
        acc = 0;
        for (int g = 1; g <= n; g++) begin
            acc += spectrum ? 64'(spec_mat[(inc - 1) * MAX_GROUPS + g - 1])
                            : 64'(scat_mat[(inc - 1) * MAX_GROUPS + g - 1]);
            if (acc > thr) return g;
        end
        return 0;
    endfunction

    function automatic void queue_rec(logic kind, logic [1:0] rxn, int grp, int cnt,
                                      logic [2:0] sts, logic lst);
        rec_t r;
        r.kind = kind;
        r.reaction = rxn;
        r.grp = grp[GRP_W-1:0];
        r.count = cnt[CNT_W-1:0];
        r.status = sts;
        r.last = lst;
        expected_records.insert(expected_records.size(), r);
    endfunction

    // Appends one row to the directed stimulus table.
    function automatic void add_row(beat_t b, logic typed, rec_t rec);
        dir_row_t row;
        row.b = b;
        row.typed = typed;
        row.rec = rec;
        dir.insert(dir.size(), row);
    endfunction

    // Applies one accepted beat to the tables and queues the records it causes.
    function automatic void predict_beat(beat_t b);
        int        inc;
        int        outg;
        int        n;
        int        idx;
        int        g;
        int        yield;
        bit [63:0] cap;
        bit [63:0] sca;
        bit [63:0] total;
        bit [63:0] thr;
        inc = int'(b.inc);
        outg = int'(b.outg);
        if (b.op == OP_WRITE) begin
            if (inc < 1 || inc > MAX_GROUPS) return;
            idx = (inc - 1) * MAX_GROUPS + outg - 1;
            case (b.sel)
                SEL_CAPTURE: xs_capture[inc - 1] = b.val;
                SEL_FISSION: xs_fission[inc - 1] = b.val;
                SEL_NUBAR:   nubar_q824[inc - 1] = b.val;
                SEL_SCATTER: begin
                    if (outg < 1 || outg > MAX_GROUPS) return;
                    scat_sum[inc - 1] = scat_sum[inc - 1] - 38'(scat_mat[idx]) + 38'(b.val);
                    scat_mat[idx] = b.val;
                end
                SEL_SPECTRUM: begin
                    if (outg < 1 || outg > MAX_GROUPS) return;
                    spec_sum[inc - 1] = spec_sum[inc - 1] - 38'(spec_mat[idx]) + 38'(b.val);
                    spec_mat[idx] = b.val;
                end
                default: ;
            endcase
            return;
        end
        n = groups_in_use();
        if (inc < 1 || inc > n) begin
            queue_rec(KIND_OUTCOME, RXN_NONE, 0, 0, STS_BAD_GROUP, 1'b1);
            return;
        end
        cap = 64'(xs_capture[inc - 1]);
        sca = 64'(scat_sum[inc - 1]);
        total = cap + sca + 64'(xs_fission[inc - 1]);
        thr = scaled(next_uniform(), total);
        if (total == 0) begin
            queue_rec(KIND_OUTCOME, RXN_NONE, 0, 0, STS_ZERO_TOTAL, 1'b1);
        end else if (cap > thr) begin
            queue_rec(KIND_OUTCOME, RXN_CAPTURE, 0, 0, STS_OK, 1'b1);
        end else if (cap + sca > thr) begin
            g = pick_group(1'b0, inc, n, scaled(next_uniform(), sca));
            queue_rec(KIND_OUTCOME, RXN_SCATTER, g, 0, g != 0 ? STS_OK : STS_EMPTY_SCAT, 1'b1);
        end else begin
            yield = int'(((64'(nubar_q824[inc - 1]) << 8) + next_uniform()) >> 32);
            if (yield > MAX_YIELD) yield = MAX_YIELD;
            queue_rec(KIND_OUTCOME, RXN_FISSION, 0, yield, STS_OK, yield == 0);
            for (int i = 0; i < yield; i++) begin
                g = pick_group(1'b1, inc, n, scaled(next_uniform(), 64'(spec_sum[inc - 1])));
                queue_rec(KIND_SECONDARY, RXN_FISSION, g, yield,
                          g != 0 ? STS_OK : STS_EMPTY_SPEC, i + 1 == yield);
            end
        end
    endfunction

    function automatic beat_t mk(logic op, logic [2:0] sel, int inc, int outg,
                                 logic [31:0] val);
        beat_t b;
        b.op = op;
        b.sel = sel;
        b.inc = inc[GRP_W-1:0];
        b.outg = outg[GRP_W-1:0];
        b.val = val;
        return b;
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Occasionally switch into or out of a stretch without any idling.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if ($urandom_range(0, 599) == 0) calm <= !calm;
    end

    // Result side back-pressure: short random stalls with an occasional long one.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 199) == 0) begin
            stall_left <= $urandom_range(15, 60);
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(0, 99) < 70);
        end
    end

    // Compare every accepted record with the oldest expectation.
    always @(posedge aclk) begin
        rec_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_records.size() == 0) begin
                fail_count++;
                $error("unexpected record: kind %0d reaction %0d group %0d",
                       m_record_kind, m_reaction, m_new_group);
            end else begin
                want = expected_records.pop_front();
                if (m_record_kind !== want.kind) begin
                    fail_count++;
                    $error("record_kind: expected %0d, got %0d", want.kind, m_record_kind);
                end
                if (m_reaction !== want.reaction) begin
                    fail_count++;
                    $error("reaction: expected %0d, got %0d", want.reaction, m_reaction);
                end
                if (m_new_group !== want.grp) begin
                    fail_count++;
                    $error("new_group: expected %0d, got %0d", want.grp, m_new_group);
                end
                if (m_secondary_count !== want.count) begin
                    fail_count++;
                    $error("secondary_count: expected %0d, got %0d",
                           want.count, m_secondary_count);
                end
                if (m_status !== want.status) begin
                    fail_count++;
                    $error("status: expected %0d, got %0d", want.status, m_status);
                end
                if (m_last !== want.last) begin
                    fail_count++;
                    $error("last: expected %0d, got %0d", want.last, m_last);
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Sends one beat after a random gap; valid stays up across back-to-back beats.
    task automatic send_beat(beat_t b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= b.op;
        s_table_select <= b.sel;
        s_incident_group <= b.inc;
        s_outgoing_group <= b.outg;
        s_table_value <= b.val;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_beat(b);
    endtask

    // Stops sending and lets every expected record and any pending write finish.
    task automatic drain();
        s_valid <= 1'b0;
        while (expected_records.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [63:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_GROUP_COUNT) begin
            groups_reg = data[6:0];
        end else begin
            rng_state = (data == 0) ? 64'd1 : data;
        end
    endtask

    // Random beat: mostly well-formed writes and collides within the groups in use.
    function automatic beat_t random_beat(output bit noise);
        int          n;
        int          r;
        logic [2:0]  sel;
        logic [31:0] v;
        n = groups_in_use();
        r = $urandom_range(0, 99);
        noise = (r < 12);
        if (r < 12) begin
            return mk(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                      $urandom_range(0, 127), $urandom_range(0, 127), $urandom);
        end
        if (r < 55) begin
            sel = 3'($urandom_range(0, 4));
            v = $urandom >> $urandom_range(0, 31);
            if (sel == SEL_NUBAR && $urandom_range(0, 9) != 0) begin
                v = $urandom_range(0, 32'h0400_0000);
            end
            return mk(OP_WRITE, sel, $urandom_range(1, n), $urandom_range(1, n), v);
        end
        return mk(OP_COLLIDE, SEL_CAPTURE, $urandom_range(1, n), 0, $urandom);
    endfunction

    initial begin
        rec_t        bad;
        rec_t        zero_tot;
        rec_t        no_yield;
        rec_t        captured;
        beat_t       b;
        bit          noise;
        int          counted;
        logic [63:0] seed;

        for (int i = 0; i < MAX_GROUPS; i++) begin
            scat_sum[i] = 0;
            spec_sum[i] = 0;
        end
        bad = '{KIND_OUTCOME, RXN_NONE, 7'd0, 5'd0, STS_BAD_GROUP, 1'b1};
        zero_tot = '{KIND_OUTCOME, RXN_NONE, 7'd0, 5'd0, STS_ZERO_TOTAL, 1'b1};
        no_yield = '{KIND_OUTCOME, RXN_FISSION, 7'd0, 5'd0, STS_OK, 1'b1};
        captured = '{KIND_OUTCOME, RXN_CAPTURE, 7'd0, 5'd0, STS_OK, 1'b1};

        // Directed beats from the reset state.
        add_row(mk(OP_COLLIDE, SEL_CAPTURE, 0, 0, 0), 1'b1, bad);
        add_row(mk(OP_COLLIDE, SEL_CAPTURE, 127, 127, 0), 1'b1, bad);
        add_row(mk(OP_COLLIDE, SEL_CAPTURE, 1, 0, 0), 1'b1, zero_tot);
        add_row(mk(OP_WRITE, 3'd5, 7, 7, 32'hFFFF_FFFF), 1'b0, rec_t'(0));
        add_row(mk(OP_WRITE, 3'd7, 7, 7, 32'hFFFF_FFFF), 1'b0, rec_t'(0));
        add_row(mk(OP_WRITE, SEL_CAPTURE, 0, 0, 32'h1234), 1'b0, rec_t'(0));
        add_row(mk(OP_WRITE, SEL_SCATTER, 7, 0, 32'h1234), 1'b0, rec_t'(0));
        add_row(mk(OP_WRITE, SEL_SPECTRUM, 7, 65, 32'h1234), 1'b0, rec_t'(0));
        add_row(mk(OP_WRITE, SEL_CAPTURE, 1, 0, 32'hFFFF_FFFF), 1'b0, rec_t'(0));
        add_row(mk(OP_COLLIDE, SEL_CAPTURE, 1, 0, 0), 1'b1, captured);
        // Scatter row whose only weight sits in the top group.
        add_row(mk(OP_WRITE, SEL_SCATTER, 2, 64, 32'hFFFF_FFFF), 1'b0, rec_t'(0));
        add_row(mk(OP_COLLIDE, SEL_CAPTURE, 2, 0, 0), 1'b0, rec_t'(0));
        // Fission with saturated yield and a one-entry spectrum.
        add_row(mk(OP_WRITE, SEL_FISSION, 4, 0, 32'hFFFF_FFFF), 1'b0, rec_t'(0));
        add_row(mk(OP_WRITE, SEL_NUBAR, 4, 0, 32'hFF00_0000), 1'b0, rec_t'(0));
        add_row(mk(OP_WRITE, SEL_SPECTRUM, 4, 1, 32'd1), 1'b0, rec_t'(0));
        add_row(mk(OP_COLLIDE, SEL_CAPTURE, 4, 0, 0), 1'b0, rec_t'(0));
        // Fission with zero nubar gives no secondaries.
        add_row(mk(OP_WRITE, SEL_FISSION, 5, 0, 32'd9), 1'b0, rec_t'(0));
        add_row(mk(OP_COLLIDE, SEL_CAPTURE, 5, 0, 0), 1'b1, no_yield);
        // Fission into an empty spectrum row.
        add_row(mk(OP_WRITE, SEL_FISSION, 6, 0, 32'd77), 1'b0, rec_t'(0));
        add_row(mk(OP_WRITE, SEL_NUBAR, 6, 0, 32'h0300_0000), 1'b0, rec_t'(0));
        add_row(mk(OP_COLLIDE, SEL_CAPTURE, 6, 0, 0), 1'b0, rec_t'(0));
        // Overwrite a matrix word so the row sum must drop the old value.
        add_row(mk(OP_WRITE, SEL_SCATTER, 64, 64, 32'h8000_0000), 1'b0, rec_t'(0));
        add_row(mk(OP_WRITE, SEL_SCATTER, 64, 64, 32'h0000_0003), 1'b0, rec_t'(0));
        add_row(mk(OP_WRITE, SEL_SCATTER, 64, 1, 32'h7FFF_FFFF), 1'b0, rec_t'(0));
        add_row(mk(OP_COLLIDE, SEL_CAPTURE, 64, 0, 0), 1'b0, rec_t'(0));

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir[i]) begin
            send_beat(dir[i].b);
            if (dir[i].typed) expected_records[expected_records.size() - 1] = dir[i].rec;
        end
        drain();

        // Narrow group counts: weight beyond the groups in use, and out-of-range groups.
        write_reg(CFG_GROUP_COUNT, 64'd2);
        send_beat(mk(OP_COLLIDE, SEL_CAPTURE, 2, 0, 0));
        drain();
        write_reg(CFG_GROUP_COUNT, 64'd1);
        write_reg(CFG_SEED, 64'd0);
        send_beat(mk(OP_COLLIDE, SEL_CAPTURE, 2, 0, 0));
        send_beat(mk(OP_COLLIDE, SEL_CAPTURE, 1, 0, 0));
        drain();
        write_reg(CFG_GROUP_COUNT, 64'd0);
        write_reg(CFG_SEED, 64'hFFFF_FFFF_FFFF_FFFF);
        send_beat(mk(OP_COLLIDE, SEL_CAPTURE, 1, 0, 0));
        send_beat(mk(OP_COLLIDE, SEL_CAPTURE, 2, 0, 0));
        drain();
        write_reg(CFG_GROUP_COUNT, 64'd127);
        send_beat(mk(OP_COLLIDE, SEL_CAPTURE, 64, 0, 0));
        send_beat(mk(OP_COLLIDE, SEL_CAPTURE, 65, 0, 0));
        drain();

        // Random phases, each with a fresh group count and seed.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0:       write_reg(CFG_GROUP_COUNT, 64'd64);
                1:       write_reg(CFG_GROUP_COUNT, 64'd1);
                default: write_reg(CFG_GROUP_COUNT, 64'($urandom_range(1, 8)));
            endcase
            seed = {$urandom, $urandom};
            write_reg(CFG_SEED, seed);
            counted = 0;
            while (counted < 13) begin
                b = random_beat(noise);
                send_beat(b);
                if (!noise) counted++;
            end
            drain();
        end

        drain();
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/mgcs_pkg.sv
rtl/mgcs_ram.sv
rtl/multigroup_collision_sampler_unit.sv
verif/tb_top.sv
